[hdl/cellular_automaton_row_gen_macros.svh]
// assertion macros for the cellular automaton row generator
// expects signals named clock and reset in the scope of each use
`ifndef CELLULAR_AUTOMATON_ROW_GEN_MACROS_SVH
`define CELLULAR_AUTOMATON_ROW_GEN_MACROS_SVH

// consequent checked in the same cycle
`define CARG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CARG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/carg_pkg.sv]
// shared types and constants of the cellular automaton row generator
// no dependencies
package carg_pkg;

   // field and register widths
   localparam int TYPE_W      = 2;
   localparam int POS_W       = 8;
   localparam int VALUE_W     = 4;
   localparam int ROW_IDX_W   = 10;
   localparam int COLUMN_W    = 6;
   localparam int CELL_RES_W  = 4;
   localparam int NC_W        = 5;
   localparam int NB_W        = 3;
   localparam int RW_W        = 7;
   localparam int GR_W        = 11;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   // rule table and neighborhood
   localparam int RULE_ENTRIES = 256;
   localparam int IDX_W        = 8;
   localparam int WIN_TAPS     = (1 << NB_W) - 1;
   localparam int MAX_ROWS     = 1024;

   // parameter defaults
   localparam int DEF_MAX_WIDTH = 64;
   localparam int DEF_CELL_BITS = 4;

   // register reset values
   localparam logic [NC_W-1:0] RST_NUM_COLORS     = 5'd4;
   localparam logic [NB_W-1:0] RST_NEIGHBOR_COUNT = 3'd3;
   localparam logic [RW_W-1:0] RST_ROW_WIDTH      = 7'd64;
   localparam logic [GR_W-1:0] RST_GRID_ROWS      = 11'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_GEN
   } state_type;

   typedef enum logic [1:0] {
      REG_NUM_COLORS     = 2'd0,
      REG_NEIGHBOR_COUNT = 2'd1,
      REG_ROW_WIDTH      = 2'd2,
      REG_GRID_ROWS      = 2'd3
   } csr_reg_type;

   typedef enum logic [TYPE_W-1:0] {
      REQ_RULE = 2'd0,
      REQ_SEED = 2'd1,
      REQ_GEN  = 2'd2
   } req_kind_type;

endpackage

[hdl/cellular_automaton_row_gen.sv]
// cellular automaton row generator: rule table, two row banks, generation pipeline
// depends on carg_pkg and cellular_automaton_row_gen_macros.svh
//
//   channel   handshake                 payload
//   req       req_valid / req_ready     req_type, req_position, req_value
//   rsp       rsp_valid / rsp_ready     rsp_row_index, rsp_column, rsp_cell_res, rsp_last
//   csr       psel / penable / pready   paddr, pwrite, pwdata, prdata
//
// rule and seed writes are performed when accepted; a generate request first runs
// ST_PREP setup for the powers of num_colors (skipped for neighbor_count zero), then
// one cell read per cycle from the single row bank port while rsp is not stalled, then a four stage pipe
// reset is synchronous; both memories read as zero through per-entry valid bits
// a stalled rsp freezes the whole generation pipe; req is taken only when idle

`include "cellular_automaton_row_gen_macros.svh"

module cellular_automaton_row_gen #(
   parameter int MAX_WIDTH = carg_pkg::DEF_MAX_WIDTH,
   parameter int CELL_BITS = carg_pkg::DEF_CELL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [carg_pkg::TYPE_W-1:0]       req_type,
   input  logic [carg_pkg::POS_W-1:0]        req_position,
   input  logic [carg_pkg::VALUE_W-1:0]      req_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [carg_pkg::ROW_IDX_W-1:0]    rsp_row_index,
   output logic [carg_pkg::COLUMN_W-1:0]     rsp_column,
   output logic [carg_pkg::CELL_RES_W-1:0]   rsp_cell_res,
   output logic                              rsp_last,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [carg_pkg::ADDR_W-1:0]       paddr,
   input  logic [carg_pkg::DATA_W-1:0]       pwdata,
   output logic [carg_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int BANK_DEPTH = 2 * (2 ** COL_W);
   localparam int TAPS       = carg_pkg::WIN_TAPS;
   localparam int RD_W       = $clog2(MAX_WIDTH + TAPS + 1);
   localparam int IDX_W      = carg_pkg::IDX_W;
   localparam int NB_W       = carg_pkg::NB_W;
   localparam int NC_W       = carg_pkg::NC_W;
   localparam int RW_W       = carg_pkg::RW_W;
   localparam int GR_W       = carg_pkg::GR_W;
   localparam int DATA_W     = carg_pkg::DATA_W;
   localparam int ROW_IDX_W  = carg_pkg::ROW_IDX_W;
   localparam int COLUMN_W   = carg_pkg::COLUMN_W;
   localparam int RES_W      = carg_pkg::CELL_RES_W;

   // ---------------------------------------------------------------- registers
   logic [NC_W-1:0] num_colors_ff;
   logic [NB_W-1:0] neighbor_count_ff;
   logic [RW_W-1:0] row_width_ff;
   logic [GR_W-1:0] grid_rows_ff;

   logic                     csr_wr;
   carg_pkg::csr_reg_type    csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_sel = carg_pkg::csr_reg_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_colors_ff     <= carg_pkg::RST_NUM_COLORS;
         neighbor_count_ff <= carg_pkg::RST_NEIGHBOR_COUNT;
         row_width_ff      <= carg_pkg::RST_ROW_WIDTH;
         grid_rows_ff      <= carg_pkg::RST_GRID_ROWS;
      end else if (csr_wr) begin
         case (csr_sel)
            carg_pkg::REG_NUM_COLORS:     num_colors_ff     <= pwdata[NC_W-1:0];
            carg_pkg::REG_NEIGHBOR_COUNT: neighbor_count_ff <= pwdata[NB_W-1:0];
            carg_pkg::REG_ROW_WIDTH:      row_width_ff      <= pwdata[RW_W-1:0];
            carg_pkg::REG_GRID_ROWS:      grid_rows_ff      <= pwdata[GR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         carg_pkg::REG_NUM_COLORS:     prdata = DATA_W'(num_colors_ff);
         carg_pkg::REG_NEIGHBOR_COUNT: prdata = DATA_W'(neighbor_count_ff);
         carg_pkg::REG_ROW_WIDTH:      prdata = DATA_W'(row_width_ff);
         carg_pkg::REG_GRID_ROWS:      prdata = DATA_W'(grid_rows_ff);
         default:                      prdata = '0;
      endcase
   end

   // --------------------------------------------------------- derived settings
   logic [WW-1:0]    eff_w;
   logic [COL_W-1:0] last_col;
   logic [GR_W-1:0]  eff_rows;
   logic [NB_W-1:0]  nbe;
   logic [NB_W-1:0]  off;
   logic [RD_W-1:0]  rd_total;
   logic [RD_W-1:0]  emit_thr;

   always_comb begin
      if (row_width_ff == '0)
         eff_w = WW'(1);
      else if (row_width_ff > MAX_WIDTH)
         eff_w = WW'(MAX_WIDTH);
      else
         eff_w = WW'(row_width_ff);

      if (grid_rows_ff == '0)
         eff_rows = GR_W'(1);
      else if (grid_rows_ff > carg_pkg::MAX_ROWS)
         eff_rows = GR_W'(carg_pkg::MAX_ROWS);
      else
         eff_rows = grid_rows_ff;

      // an empty neighborhood still runs one window read, its taps weigh zero
      nbe      = (neighbor_count_ff == '0) ? NB_W'(1) : neighbor_count_ff;
      off      = (neighbor_count_ff == '0) ? '0 : ((neighbor_count_ff - 1'b1) >> 1);
      last_col = COL_W'(eff_w - 1'b1);
      rd_total = RD_W'(nbe) + RD_W'(eff_w) - RD_W'(1);
      emit_thr = RD_W'(nbe) - RD_W'(1);
   end

   // ------------------------------------------------------------- memories
   logic [CELL_BITS-1:0] bank_mem [BANK_DEPTH];
   logic [BANK_DEPTH-1:0] bank_vld_ff;
   logic [CELL_BITS-1:0] rule_mem [carg_pkg::RULE_ENTRIES];
   logic [carg_pkg::RULE_ENTRIES-1:0] rule_vld_ff;

   logic                  bk_we;
   logic [COL_W:0]        bk_wa;
   logic [CELL_BITS-1:0]  bk_wd;
   logic [COL_W:0]        rd_addr;
   logic                  rule_we;
   logic [IDX_W-1:0]      idx_sum;

   logic [CELL_BITS-1:0]  bk_rd_ff;
   logic                  bk_rdv_ff;
   logic [CELL_BITS-1:0]  rule_rd_ff;
   logic                  rule_rdv_ff;

   // ------------------------------------------------------ control and datapath
   carg_pkg::state_type state_ff, state_in;
   logic [7:0]           pw_ff, pw_in;
   logic [7:0]           tp_ff [TAPS];
   logic [7:0]           tp_in [TAPS];
   logic [CELL_BITS-1:0] win_ff [TAPS];
   logic [CELL_BITS-1:0] win_in [TAPS];
   logic [7:0]           prod_ff [TAPS];
   logic [7:0]           prod_in [TAPS];
   logic [NB_W-1:0]      k_ff, k_in;
   logic [COL_W-1:0]     rd_col_ff, rd_col_in;
   logic [RD_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [COL_W-1:0]     x_ff, x_in;
   logic                 p1_ff, p1_in;
   logic                 p1_emit_ff, p1_emit_in;
   logic                 p2_ff, p2_in;
   logic                 p3_ff, p3_in;
   logic                 p4_ff, p4_in;
   logic                 bank_sel_ff, bank_sel_in;
   logic [ROW_IDX_W-1:0] row_cnt_ff, row_cnt_in;
   logic [GR_W-1:0]      row_cnt_nx;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0] rsp_row_index_ff, rsp_row_index_in;
   logic [COLUMN_W-1:0]  rsp_column_ff, rsp_column_in;
   logic [RES_W-1:0]     rsp_cell_res_ff, rsp_cell_res_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_acc;
   logic                 adv;
   logic                 issue;
   logic [CELL_BITS-1:0] cell_new;
   logic                 cell_last;

   assign req_ready = (state_ff == carg_pkg::ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   // the whole pipe moves only when the output register can take a cell
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign issue     = (state_ff == carg_pkg::ST_GEN) && (rd_cnt_ff < rd_total) && adv;
   assign rd_addr   = {bank_sel_ff, rd_col_ff};
   assign cell_new  = rule_rdv_ff ? rule_rd_ff : '0;
   assign cell_last = (x_ff == last_col);
   assign rule_we   = req_acc && (req_type == carg_pkg::REQ_RULE);
   assign row_cnt_nx = GR_W'(row_cnt_ff) + GR_W'(1);

   always_comb begin
      idx_sum = '0;
      for (int j = 0; j < TAPS; j++)
         idx_sum = idx_sum + prod_ff[j];
   end

   always_comb begin
      state_in         = state_ff;
      pw_in            = pw_ff;
      tp_in            = tp_ff;
      win_in           = win_ff;
      prod_in          = prod_ff;
      k_in             = k_ff;
      rd_col_in        = rd_col_ff;
      rd_cnt_in        = rd_cnt_ff;
      x_in             = x_ff;
      p1_in            = p1_ff;
      p1_emit_in       = p1_emit_ff;
      p2_in            = p2_ff;
      p3_in            = p3_ff;
      p4_in            = p4_ff;
      bank_sel_in      = bank_sel_ff;
      row_cnt_in       = row_cnt_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_row_index_in = rsp_row_index_ff;
      rsp_column_in    = rsp_column_ff;
      rsp_cell_res_in  = rsp_cell_res_ff;
      rsp_last_in      = rsp_last_ff;
      bk_we            = 1'b0;
      bk_wa            = {bank_sel_ff, x_ff};
      bk_wd            = cell_new;

      case (state_ff)
         carg_pkg::ST_IDLE: begin
            if (req_acc && (req_type == carg_pkg::REQ_SEED)) begin
               row_cnt_in = '0;
               if (req_position < MAX_WIDTH) begin
                  bk_we = 1'b1;
                  bk_wa = {bank_sel_ff, req_position[COL_W-1:0]};
                  bk_wd = CELL_BITS'(req_value);
               end
            end
            if (req_acc && (req_type == carg_pkg::REQ_GEN)) begin
               pw_in     = 8'd1;
               k_in      = '0;
               rd_col_in = '0;
               rd_cnt_in = '0;
               x_in      = '0;
               for (int j = 0; j < TAPS; j++) begin
                  tp_in[j]  = '0;
                  win_in[j] = '0;
               end
               state_in = (neighbor_count_ff == '0) ? carg_pkg::ST_GEN : carg_pkg::ST_PREP;
            end
         end
         carg_pkg::ST_PREP: begin
            // weights shift in from the top: lowest power ends at the oldest cell
            for (int j = 0; j < TAPS - 1; j++)
               tp_in[j] = tp_ff[j+1];
            tp_in[TAPS-1] = pw_ff;
            pw_in = 8'(pw_ff * 8'(num_colors_ff));
            // walk the start column back by the window offset, wrapping
            if (k_ff < off)
               rd_col_in = (rd_col_ff == '0) ? last_col : rd_col_ff - 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == neighbor_count_ff - 1'b1)
               state_in = carg_pkg::ST_GEN;
         end
         carg_pkg::ST_GEN: begin
            if (issue) begin
               rd_col_in = (rd_col_ff == last_col) ? '0 : rd_col_ff + 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
         default: state_in = carg_pkg::ST_IDLE;
      endcase

      if (adv) begin
         p1_in      = issue;
         p1_emit_in = (rd_cnt_ff >= emit_thr);
         p2_in      = p1_ff & p1_emit_ff;
         p3_in      = p2_ff;
         p4_in      = p3_ff;
         if (p1_ff) begin
            for (int j = 0; j < TAPS - 1; j++)
               win_in[j] = win_ff[j+1];
            win_in[TAPS-1] = bk_rdv_ff ? bk_rd_ff : '0;
         end
         for (int j = 0; j < TAPS; j++)
            prod_in[j] = 8'(win_ff[j] * tp_ff[j]);

         rsp_valid_in = p4_ff;
         if (p4_ff) begin
            rsp_row_index_in = row_cnt_ff;
            rsp_column_in    = COLUMN_W'(x_ff);
            rsp_cell_res_in  = RES_W'(cell_new);
            rsp_last_in      = cell_last;
            x_in             = x_ff + 1'b1;
            bk_we            = 1'b1;
            bk_wa            = {~bank_sel_ff, x_ff};
            bk_wd            = cell_new;
            if (cell_last) begin
               state_in    = carg_pkg::ST_IDLE;
               bank_sel_in = ~bank_sel_ff;
               row_cnt_in  = (row_cnt_nx >= eff_rows) ? '0 : row_cnt_nx[ROW_IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= carg_pkg::ST_IDLE;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         p3_ff        <= 1'b0;
         p4_ff        <= 1'b0;
         bank_sel_ff  <= 1'b0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         p3_ff        <= p3_in;
         p4_ff        <= p4_in;
         bank_sel_ff  <= bank_sel_in;
         row_cnt_ff   <= row_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pw_ff            <= pw_in;
      tp_ff            <= tp_in;
      win_ff           <= win_in;
      prod_ff          <= prod_in;
      k_ff             <= k_in;
      rd_col_ff        <= rd_col_in;
      rd_cnt_ff        <= rd_cnt_in;
      x_ff             <= x_in;
      p1_emit_ff       <= p1_emit_in;
      rsp_row_index_ff <= rsp_row_index_in;
      rsp_column_ff    <= rsp_column_in;
      rsp_cell_res_ff  <= rsp_cell_res_in;
      rsp_last_ff      <= rsp_last_in;
   end

   // row banks: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (bk_we)
         bank_mem[bk_wa] <= bk_wd;
      if (adv) begin
         bk_rd_ff  <= bank_mem[rd_addr];
         bk_rdv_ff <= bank_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         bank_vld_ff <= '0;
      else if (bk_we)
         bank_vld_ff[bk_wa] <= 1'b1;
   end

   // rule table: written by rule requests, read by the neighborhood index
   always_ff @(posedge clock) begin
      if (rule_we)
         rule_mem[req_position] <= CELL_BITS'(req_value);
      if (adv) begin
         rule_rd_ff  <= rule_mem[idx_sum];
         rule_rdv_ff <= rule_vld_ff[idx_sum];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rule_vld_ff <= '0;
      else if (rule_we)
         rule_vld_ff[req_position] <= 1'b1;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_cell_res  = rsp_cell_res_ff;
   assign rsp_last      = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   `CARG_ASSERT_NOW(a_pipe_empty_when_not_gen, state_ff != carg_pkg::ST_GEN, !(p1_ff || p2_ff || p3_ff || p4_ff), "generation pipe busy outside a row")
   `CARG_ASSERT_NOW(a_reads_bounded, state_ff == carg_pkg::ST_GEN, rd_cnt_ff <= rd_total, "row bank read count overran the row")
   `CARG_ASSERT_NOW(a_write_next_bank, (state_ff == carg_pkg::ST_GEN) && bk_we, bk_wa[COL_W] != bank_sel_ff, "generated cell written into the current row bank")
   `CARG_ASSERT_NEXT(a_row_end_idle, adv && p4_ff && cell_last, (state_ff == carg_pkg::ST_IDLE) && rsp_valid_ff && rsp_last_ff, "last cell did not end the row")

endmodule
